/* rtl/wpsd_pkg.sv */
// Package for the WAV PCM stream decoder: shared constants, codes and the
// queue entry type passed from the parser front to the sample back end.
// No dependencies.
package wpsd_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int CH_W              = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W             = 16 + $clog2(MAX_CHANNELS);
    localparam int DIV_CNT_W         = $clog2(SUM_W + 1);
    localparam int MIN_FILE_BYTES    = 44;
    localparam int FMT_CAPTURE_BYTES = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_INFO   = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_MAGIC   = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_NO_DATA = 3'd2,
        ERR_NO_CHAN = 3'd3,
        ERR_FORMAT  = 3'd4
    } err_t;

    // One entry per input byte that causes any result.
    typedef struct packed {
        logic               has_sample;
        logic signed [15:0] sample;
        logic               frame_end;
        logic [CH_W-1:0]    chans_div;
        logic               has_info;
        logic [31:0]        rate;
        logic [15:0]        chans;
        logic               has_term;
        kind_t              term_kind;
        err_t               err;
    } entry_t;

    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h52;
            4'd1:    val = 8'h49;
            4'd2:    val = 8'h46;
            4'd3:    val = 8'h46;
            4'd8:    val = 8'h57;
            4'd9:    val = 8'h41;
            4'd10:   val = 8'h56;
            4'd11:   val = 8'h45;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* rtl/wpsd_in_if.sv */
// Byte input channel of the WAV PCM stream decoder.
// Depends on nothing.
interface wpsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_file;

    modport source (output valid, output byte_value, output end_of_file, input ready);
    modport sink   (input valid, input byte_value, input end_of_file, output ready);
endinterface

/* rtl/wpsd_out_if.sv */
// Result output channel of the WAV PCM stream decoder.
// Depends on wpsd_pkg.
interface wpsd_out_if;
    logic                  valid;
    logic                  ready;
    wpsd_pkg::kind_t       kind;
    logic signed [15:0]    mono_sample;
    logic [31:0]           rate_hz;
    logic [15:0]           channel_count;
    logic [2:0]            error_code;
    logic                  last;

    modport source (output valid, output kind, output mono_sample, output rate_hz,
                    output channel_count, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input mono_sample, input rate_hz,
                    input channel_count, input error_code, input last, output ready);
endinterface

/* rtl/wpsd_front.sv */
// Parser front: walks RIFF chunks byte by byte, captures the fmt fields,
// assembles samples and pushes queue entries. Depends on wpsd_pkg, wpsd_in_if.
module wpsd_front (
    input  logic                clk,
    input  logic                rst_n,
    wpsd_in_if.sink             bytes,
    input  logic                q_full,
    output logic                q_push,
    output wpsd_pkg::entry_t    q_entry
);

    typedef enum logic [7:0] {
        PH_MAGIC    = 8'b0000_0001,
        PH_CHUNK_ID = 8'b0000_0010,
        PH_SIZE     = 8'b0000_0100,
        PH_BODY     = 8'b0000_1000,
        PH_PAD      = 8'b0001_0000,
        PH_DATA     = 8'b0010_0000,
        PH_TAIL     = 8'b0100_0000,
        PH_FAIL     = 8'b1000_0000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [5:0]                  pos_reg, pos_next;
    logic [31:0]                 tag_reg, tag_next;
    logic [31:0]                 left_reg, left_next;
    logic [15:0]                 fmt_reg, fmt_next;
    logic [15:0]                 chs_reg, chs_next;
    logic [15:0]                 bps_reg, bps_next;
    logic [31:0]                 rate_reg, rate_next;
    logic [23:0]                 asm_reg, asm_next;
    logic [1:0]                  bis_reg, bis_next;
    logic [wpsd_pkg::CH_W-1:0]   chi_reg, chi_next;
    logic                        pad_reg, pad_next;
    logic [4:0]                  foff_reg, foff_next;
    wpsd_pkg::err_t              perr_reg, perr_next;

    logic                        accept;
    logic [7:0]                  b;
    logic [31:0]                 size_word;
    logic [31:0]                 asm_word;
    logic                        usable;
    logic                        smp_done;
    logic [wpsd_pkg::CH_W:0]     chi_inc;

    function automatic logic [31:0] put_byte32(input logic [31:0] v, input logic [1:0] k,
                                               input logic [7:0] d);
        logic [31:0] r;
        r = v;
        case (k)
            2'd0:    r[7:0]   = d;
            2'd1:    r[15:8]  = d;
            2'd2:    r[23:16] = d;
            default: r[31:24] = d;
        endcase
        return r;
    endfunction

    // Float to Q1.15: scale by 32768, truncate toward zero, saturate; NaN gives 0.
    function automatic logic signed [15:0] float_to_q15(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [22:0] man;
        logic        sat;
        logic        nan;
        logic [23:0] mag;
        logic [7:0]  rs;
        logic [15:0] res;
        ex  = bits[30:23];
        man = bits[22:0];
        sat = 1'b0;
        nan = 1'b0;
        mag = '0;
        rs  = 8'd135 - ex;
        if (ex == 8'hFF)
        begin
            if (man != '0)
                nan = 1'b1;
            else
                sat = 1'b1;
        end
        else if (ex == 8'd0)
            mag = '0;
        else if (ex >= 8'd135)
            sat = 1'b1;
        else if (rs <= 8'd23)
            mag = {1'b1, man} >> rs[4:0];
        if (nan)
            res = 16'h0000;
        else if (bits[31])
            res = (sat || mag >= 24'd32768) ? 16'h8000 : (~mag[15:0]) + 16'd1;
        else
            res = (sat || mag > 24'd32767) ? 16'h7FFF : mag[15:0];
        return res;
    endfunction

    assign accept      = bytes.valid && bytes.ready;
    assign bytes.ready = !q_full;
    assign b           = bytes.byte_value;
    assign size_word   = put_byte32(left_reg, bis_reg, b);
    assign asm_word    = put_byte32({8'd0, asm_reg}, bis_reg, b);
    assign usable      = (chs_reg <= 16'(wpsd_pkg::MAX_CHANNELS)) &&
                         ((fmt_reg == wpsd_pkg::FMT_PCM && bps_reg == 16'd16) ||
                          (fmt_reg == wpsd_pkg::FMT_FLOAT && bps_reg == 16'd32));
    assign smp_done    = (fmt_reg == wpsd_pkg::FMT_FLOAT) ? (bis_reg == 2'd3)
                                                          : (bis_reg == 2'd1);
    assign chi_inc     = {1'b0, chi_reg} + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tag_next   = tag_reg;
        left_next  = left_reg;
        fmt_next   = fmt_reg;
        chs_next   = chs_reg;
        bps_next   = bps_reg;
        rate_next  = rate_reg;
        asm_next   = asm_reg;
        bis_next   = bis_reg;
        chi_next   = chi_reg;
        pad_next   = pad_reg;
        foff_next  = foff_reg;
        perr_next  = perr_reg;
        q_entry    = '0;
        q_push     = 1'b0;
        if (accept)
        begin
            if (pos_reg != 6'h3F)
                pos_next = pos_reg + 6'd1;
            case (phase_reg)
                PH_MAGIC:
                begin
                    if ((pos_reg < 6'd4 || pos_reg >= 6'd8) &&
                        b != wpsd_pkg::magic_byte(pos_reg[3:0]))
                    begin
                        perr_next  = wpsd_pkg::ERR_MAGIC;
                        phase_next = PH_FAIL;
                    end
                    else if (pos_reg >= 6'd11)
                    begin
                        phase_next = PH_CHUNK_ID;
                        tag_next   = '0;
                        bis_next   = '0;
                    end
                end
                PH_CHUNK_ID:
                begin
                    tag_next = {tag_reg[23:0], b};
                    if (bis_reg == 2'd3)
                    begin
                        bis_next   = '0;
                        left_next  = '0;
                        phase_next = PH_SIZE;
                    end
                    else
                        bis_next = bis_reg + 2'd1;
                end
                PH_SIZE:
                begin
                    left_next = size_word;
                    if (bis_reg != 2'd3)
                        bis_next = bis_reg + 2'd1;
                    else
                    begin
                        bis_next = '0;
                        if (tag_reg == wpsd_pkg::TAG_DATA)
                        begin
                            if (chs_reg == '0)
                            begin
                                perr_next  = wpsd_pkg::ERR_NO_CHAN;
                                phase_next = PH_FAIL;
                            end
                            else if (!usable)
                            begin
                                perr_next  = wpsd_pkg::ERR_FORMAT;
                                phase_next = PH_FAIL;
                            end
                            else
                            begin
                                q_entry.has_info = 1'b1;
                                q_entry.rate     = rate_reg;
                                q_entry.chans    = chs_reg;
                                asm_next         = '0;
                                chi_next         = '0;
                                phase_next       = (size_word != '0) ? PH_DATA : PH_TAIL;
                            end
                        end
                        else
                        begin
                            pad_next = size_word[0];
                            if (tag_reg == wpsd_pkg::TAG_FMT)
                            begin
                                foff_next = '0;
                                if (size_word < 32'(wpsd_pkg::FMT_CAPTURE_BYTES))
                                    fmt_next = '0;
                            end
                            if (size_word != '0)
                                phase_next = PH_BODY;
                            else
                            begin
                                phase_next = PH_CHUNK_ID;
                                tag_next   = '0;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    if (tag_reg == wpsd_pkg::TAG_FMT &&
                        foff_reg < 5'(wpsd_pkg::FMT_CAPTURE_BYTES))
                    begin
                        case (foff_reg)
                            5'd0:  fmt_next[7:0]    = b;
                            5'd1:  fmt_next[15:8]   = b;
                            5'd2:  chs_next[7:0]    = b;
                            5'd3:  chs_next[15:8]   = b;
                            5'd4:  rate_next[7:0]   = b;
                            5'd5:  rate_next[15:8]  = b;
                            5'd6:  rate_next[23:16] = b;
                            5'd7:  rate_next[31:24] = b;
                            5'd14: bps_next[7:0]    = b;
                            5'd15: bps_next[15:8]   = b;
                            default: ;
                        endcase
                        foff_next = foff_reg + 5'd1;
                    end
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        if (pad_reg)
                            phase_next = PH_PAD;
                        else
                        begin
                            phase_next = PH_CHUNK_ID;
                            tag_next   = '0;
                            bis_next   = '0;
                        end
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_CHUNK_ID;
                    tag_next   = '0;
                    bis_next   = '0;
                end
                PH_DATA:
                begin
                    if (smp_done)
                    begin
                        q_entry.has_sample = 1'b1;
                        if (fmt_reg == wpsd_pkg::FMT_FLOAT)
                            q_entry.sample = float_to_q15({b, asm_reg});
                        else
                            q_entry.sample = {b, asm_reg[7:0]};
                        q_entry.chans_div = chs_reg[wpsd_pkg::CH_W-1:0];
                        bis_next = '0;
                        asm_next = '0;
                        if ({16'd0, chi_inc} >= {{(wpsd_pkg::CH_W+1){1'b0}}, chs_reg})
                        begin
                            q_entry.frame_end = 1'b1;
                            chi_next          = '0;
                        end
                        else
                            chi_next = chi_inc[wpsd_pkg::CH_W-1:0];
                    end
                    else
                    begin
                        asm_next = asm_word[23:0];
                        bis_next = bis_reg + 2'd1;
                    end
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                        phase_next = PH_TAIL;
                end
                default: ;
            endcase

            if (bytes.end_of_file)
            begin
                q_entry.has_term = 1'b1;
                if (phase_next == PH_DATA || phase_next == PH_TAIL)
                    q_entry.term_kind = wpsd_pkg::KIND_END;
                else
                begin
                    q_entry.term_kind = wpsd_pkg::KIND_ERROR;
                    if (pos_next < 6'(wpsd_pkg::MIN_FILE_BYTES))
                        q_entry.err = wpsd_pkg::ERR_SHORT;
                    else if (phase_next == PH_FAIL)
                        q_entry.err = perr_reg == perr_next ? perr_reg : perr_next;
                    else
                        q_entry.err = wpsd_pkg::ERR_NO_DATA;
                end
                phase_next = PH_MAGIC;
                pos_next   = '0;
                tag_next   = '0;
                left_next  = '0;
                fmt_next   = '0;
                chs_next   = 16'd1;
                bps_next   = 16'd16;
                rate_next  = '0;
                asm_next   = '0;
                bis_next   = '0;
                chi_next   = '0;
                pad_next   = 1'b0;
                foff_next  = '0;
                perr_next  = wpsd_pkg::ERR_MAGIC;
            end
            q_push = q_entry.has_sample || q_entry.has_info || q_entry.has_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            tag_reg   <= '0;
            left_reg  <= '0;
            fmt_reg   <= '0;
            chs_reg   <= 16'd1;
            bps_reg   <= 16'd16;
            rate_reg  <= '0;
            asm_reg   <= '0;
            bis_reg   <= '0;
            chi_reg   <= '0;
            pad_reg   <= 1'b0;
            foff_reg  <= '0;
            perr_reg  <= wpsd_pkg::ERR_MAGIC;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            fmt_reg   <= fmt_next;
            chs_reg   <= chs_next;
            bps_reg   <= bps_next;
            rate_reg  <= rate_next;
            asm_reg   <= asm_next;
            bis_reg   <= bis_next;
            chi_reg   <= chi_next;
            pad_reg   <= pad_next;
            foff_reg  <= foff_next;
            perr_reg  <= perr_next;
        end
    end

endmodule

/* rtl/wpsd_queue.sv */
// Short first-in first-out queue of parser entries between front and back.
// Depends on wpsd_pkg.
module wpsd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpsd_pkg::entry_t    push_entry,
    input  logic                pop,
    output wpsd_pkg::entry_t    head,
    output logic                full,
    output logic                empty
);

    wpsd_pkg::entry_t                  slot_reg [wpsd_pkg::QUEUE_DEPTH];
    logic [wpsd_pkg::QUEUE_AW-1:0]     wr_reg, wr_next;
    logic [wpsd_pkg::QUEUE_AW-1:0]     rd_reg, rd_next;
    logic [wpsd_pkg::QUEUE_AW:0]       cnt_reg, cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = cnt_reg == (wpsd_pkg::QUEUE_AW+1)'(wpsd_pkg::QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (wpsd_pkg::QUEUE_AW+1)'(do_push) -
                   (wpsd_pkg::QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/wpsd_back.sv */
// Back end: sums channel samples per frame, divides by the channel count
// with a bit-serial divider and drives the result register.
// Depends on wpsd_pkg and wpsd_out_if.
module wpsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wpsd_pkg::entry_t    head,
    input  logic                empty,
    output logic                pop,
    wpsd_out_if.source          results
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b00_0001,
        B_INFO = 6'b00_0010,
        B_ACC  = 6'b00_0100,
        B_DIV  = 6'b00_1000,
        B_SMP  = 6'b01_0000,
        B_TERM = 6'b10_0000
    } bstate_t;

    typedef struct packed {
        wpsd_pkg::kind_t    kind;
        logic signed [15:0] mono_sample;
        logic [31:0]        rate_hz;
        logic [15:0]        channel_count;
        logic [2:0]         error_code;
        logic               last;
    } result_t;

    bstate_t                            st_reg, st_next;
    wpsd_pkg::entry_t                   cur_reg, cur_next;
    logic signed [wpsd_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [wpsd_pkg::SUM_W-1:0]         q_reg, q_next;
    logic [wpsd_pkg::CH_W-1:0]          r_reg, r_next;
    logic [wpsd_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               neg_reg, neg_next;
    logic                               ov_reg, ov_next;
    result_t                            out_reg, out_next;

    logic                               out_free;
    logic signed [wpsd_pkg::SUM_W-1:0]  acc;
    logic [wpsd_pkg::CH_W:0]            trial;
    logic                               ge;
    logic [15:0]                        mean;

    assign out_free = !ov_reg || results.ready;
    assign acc      = sum_reg + wpsd_pkg::SUM_W'(cur_reg.sample);
    assign trial    = {r_reg, q_reg[wpsd_pkg::SUM_W-1]};
    assign ge       = trial >= {1'b0, cur_reg.chans_div};
    assign mean     = neg_reg ? (~q_reg[15:0]) + 16'd1 : q_reg[15:0];

    always_comb
    begin
        st_next  = st_reg;
        cur_next = cur_reg;
        sum_next = sum_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        ov_next  = ov_reg && !results.ready;
        out_next = out_reg;
        pop      = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    if (head.has_info)
                        st_next = B_INFO;
                    else if (head.has_sample)
                        st_next = B_ACC;
                    else
                        st_next = B_TERM;
                end
            end
            B_INFO:
            begin
                if (out_free)
                begin
                    out_next               = '0;
                    out_next.kind          = wpsd_pkg::KIND_INFO;
                    out_next.rate_hz       = cur_reg.rate;
                    out_next.channel_count = cur_reg.chans;
                    ov_next                = 1'b1;
                    sum_next               = '0;
                    st_next                = cur_reg.has_term ? B_TERM : B_IDLE;
                end
            end
            B_ACC:
            begin
                if (cur_reg.frame_end)
                begin
                    neg_next = acc[wpsd_pkg::SUM_W-1];
                    q_next   = acc[wpsd_pkg::SUM_W-1] ? -acc : acc;
                    r_next   = '0;
                    cnt_next = wpsd_pkg::DIV_CNT_W'(wpsd_pkg::SUM_W);
                    st_next  = B_DIV;
                end
                else
                begin
                    sum_next = acc;
                    st_next  = cur_reg.has_term ? B_TERM : B_IDLE;
                end
            end
            B_DIV:
            begin
                r_next   = ge ? wpsd_pkg::CH_W'(trial - {1'b0, cur_reg.chans_div})
                              : trial[wpsd_pkg::CH_W-1:0];
                q_next   = {q_reg[wpsd_pkg::SUM_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == wpsd_pkg::DIV_CNT_W'(1))
                    st_next = B_SMP;
            end
            B_SMP:
            begin
                if (out_free)
                begin
                    out_next             = '0;
                    out_next.kind        = wpsd_pkg::KIND_SAMPLE;
                    out_next.mono_sample = mean;
                    ov_next              = 1'b1;
                    sum_next             = '0;
                    st_next              = cur_reg.has_term ? B_TERM : B_IDLE;
                end
            end
            B_TERM:
            begin
                if (out_free)
                begin
                    out_next      = '0;
                    out_next.kind = cur_reg.term_kind;
                    if (cur_reg.term_kind == wpsd_pkg::KIND_ERROR)
                        out_next.error_code = cur_reg.err;
                    out_next.last = 1'b1;
                    ov_next       = 1'b1;
                    sum_next      = '0;
                    st_next       = B_IDLE;
                end
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= B_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    assign results.valid         = ov_reg;
    assign results.kind          = out_reg.kind;
    assign results.mono_sample   = out_reg.mono_sample;
    assign results.rate_hz       = out_reg.rate_hz;
    assign results.channel_count = out_reg.channel_count;
    assign results.error_code    = out_reg.error_code;
    assign results.last          = out_reg.last;

endmodule

/* rtl/wav_pcm_stream_decoder_unit.sv */
// Top level of the WAV PCM stream decoder.
// Depends on wpsd_pkg, wpsd_in_if, wpsd_out_if, wpsd_front, wpsd_queue, wpsd_back.
//
// The decoder takes a WAV file one byte per transaction on the bytes channel,
// with end_of_file set on the final byte, and returns result transactions on
// the results channel. The parser front takes one byte every cycle while its
// four-entry queue has room; it checks the RIFF and WAVE magic, walks chunks
// with word padding, captures the fmt fields and assembles PCM16 or float32
// samples, converting floats to Q1.15 with saturation as the last byte of
// each sample arrives. The back end sums the samples of each frame and
// divides the sum by the channel count, truncating toward zero, with a
// bit-serial divider that yields one quotient bit per step over the 16 plus
// log2(MAX_CHANNELS) bits of the sum, 19 at the default of eight channels.
// Byte input runs at one per cycle until the queue fills, so the sustained
// rate is set by the back end and its divider. An info result comes when a
// usable data chunk header completes, and an end or error result, flagged
// with last, answers the end-of-file byte; the decoder then starts over on
// the next byte. A finished result waits in the output register while the
// front keeps taking bytes.
module wav_pcm_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    wpsd_in_if.sink     bytes,
    wpsd_out_if.source  results
);

    wpsd_pkg::entry_t   push_entry;
    wpsd_pkg::entry_t   head;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    // Parser front: accepts and classifies bytes.
    wpsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .q_full  (full),
        .q_push  (push),
        .q_entry (push_entry)
    );

    // Decouples byte intake from the divider in the back end.
    wpsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // Back end: frame sums, division and the result register.
    wpsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .results (results)
    );

endmodule

/* dv/wpsd_checker.sv */
`timescale 1ns / 1ps
// Checker for the WAV PCM stream decoder: watches both channels, predicts results.
// Depends on wpsd_pkg, wpsd_in_if and wpsd_out_if.
module wpsd_checker
    import wpsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    wpsd_in_if    bytes,
    wpsd_out_if   results,
    output int    errors,
    output int    pending
);

    localparam logic [2:0] P_MAGIC = 3'd0, P_ID = 3'd1, P_SIZE = 3'd2, P_BODY = 3'd3,
                           P_PAD = 3'd4, P_DATA = 3'd5, P_TAIL = 3'd6, P_FAIL = 3'd7;

    typedef struct {
        kind_t              kind;
        logic signed [15:0] sample;
        logic [31:0]        rate;
        logic [15:0]        chans;
        err_t               err;
        logic               last;
    } result_t;

    result_t expected_q[$];

    logic [2:0]  phase;
    logic [31:0] pos, tag, left, rate_seen, assembly;
    logic [15:0] fmt_code, chans_seen, bits_seen;
    logic [1:0]  sub_idx;
    int          chan_idx, sum;
    logic        pad_flag;
    int          fmt_off;
    err_t        held_err;

    assign pending = expected_q.size();

    task automatic clear_state();
        phase = P_MAGIC; pos = 0; tag = 0; left = 0; fmt_code = 0; chans_seen = 1;
        bits_seen = 16; rate_seen = 0; assembly = 0; sub_idx = 0; chan_idx = 0;
        sum = 0; pad_flag = 0; fmt_off = 0; held_err = ERR_MAGIC;
    endtask

    task automatic push(kind_t k, int s, logic [31:0] r, logic [15:0] c, err_t e, logic l);
        result_t x;
        x.kind = k; x.sample = s[15:0]; x.rate = r; x.chans = c; x.err = e; x.last = l;
        expected_q.push_back(x);
    endtask

    function automatic int float_q15(logic [31:0] f);
        logic [7:0]  ex;
        logic [31:0] mag;
        int          sh;
        ex = f[30:23];
        if (ex == 8'hFF) begin
            if (f[22:0] != 0) return 0;
            mag = 32'hFFFF_FFFF;
        end else if (ex == 0) mag = 0;
        else if (ex >= 135) mag = 32'hFFFF_FFFF;
        else begin
            sh = 135 - ex;
            mag = (sh > 23) ? 0 : ({8'd0, 1'b1, f[22:0]} >> sh);
        end
        if (f[31]) return (mag >= 32768) ? -32768 : -int'(mag);
        return (mag > 32767) ? 32767 : int'(mag);
    endfunction

    function automatic bit format_ok();
        if (chans_seen > MAX_CHANNELS) return 0;
        return (fmt_code == FMT_PCM && bits_seen == 16) ||
               (fmt_code == FMT_FLOAT && bits_seen == 32);
    endfunction

    task automatic to_next_chunk();
        phase = P_ID; tag = 0; sub_idx = 0;
    endtask

    // Advances the decoder state by one byte and queues the results it causes.
    task automatic predict_byte(logic [7:0] b, logic eof);
        logic [31:0] idx;
        int          bps, s;
        idx = pos;
        if (pos != 32'hFFFF_FFFF) pos++;
        case (phase)
            P_MAGIC: begin
                if ((idx < 4 || idx >= 8) && b != magic_byte(idx[3:0])) begin
                    held_err = ERR_MAGIC;
                    phase = P_FAIL;
                end else if (idx >= 11) to_next_chunk();
            end
            P_ID: begin
                tag = {tag[23:0], b};
                if (sub_idx == 3) begin
                    sub_idx = 0; left = 0; phase = P_SIZE;
                end else sub_idx++;
            end
            P_SIZE: begin
                left[8*sub_idx +: 8] = b;
                if (sub_idx != 3) sub_idx++;
                else begin
                    sub_idx = 0;
                    if (tag == TAG_DATA) begin
                        if (chans_seen == 0) begin
                            held_err = ERR_NO_CHAN; phase = P_FAIL;
                        end else if (!format_ok()) begin
                            held_err = ERR_FORMAT; phase = P_FAIL;
                        end else begin
                            push(KIND_INFO, 0, rate_seen, chans_seen, ERR_MAGIC, 0);
                            assembly = 0; chan_idx = 0; sum = 0;
                            phase = (left != 0) ? P_DATA : P_TAIL;
                        end
                    end else begin
                        pad_flag = left[0];
                        if (tag == TAG_FMT) begin
                            fmt_off = 0;
                            if (left < FMT_CAPTURE_BYTES) fmt_code = 0;
                        end
                        if (left != 0) phase = P_BODY;
                        else to_next_chunk();
                    end
                end
            end
            P_BODY: begin
                if (tag == TAG_FMT && fmt_off < FMT_CAPTURE_BYTES) begin
                    if (fmt_off < 2) fmt_code[8*fmt_off +: 8] = b;
                    else if (fmt_off < 4) chans_seen[8*(fmt_off-2) +: 8] = b;
                    else if (fmt_off < 8) rate_seen[8*(fmt_off-4) +: 8] = b;
                    else if (fmt_off >= 14) bits_seen[8*(fmt_off-14) +: 8] = b;
                    fmt_off++;
                end
                left--;
                if (left == 0) begin
                    if (pad_flag) phase = P_PAD;
                    else to_next_chunk();
                end
            end
            P_PAD: to_next_chunk();
            P_DATA: begin
                bps = (fmt_code == FMT_FLOAT) ? 4 : 2;
                assembly[8*sub_idx +: 8] = b;
                if (sub_idx + 1 >= bps) begin
                    s = (bps == 4) ? float_q15(assembly) : int'($signed(assembly[15:0]));
                    sum += s;
                    sub_idx = 0; assembly = 0; chan_idx++;
                    if (chan_idx >= chans_seen) begin
                        push(KIND_SAMPLE, sum / int'(chans_seen), 0, 0, ERR_MAGIC, 0);
                        sum = 0; chan_idx = 0;
                    end
                end else sub_idx++;
                left--;
                if (left == 0) phase = P_TAIL;
            end
            default: ;
        endcase
        if (eof) begin
            if (phase == P_DATA || phase == P_TAIL) push(KIND_END, 0, 0, 0, ERR_MAGIC, 1);
            else if (pos < MIN_FILE_BYTES) push(KIND_ERROR, 0, 0, 0, ERR_SHORT, 1);
            else if (phase == P_FAIL) push(KIND_ERROR, 0, 0, 0, held_err, 1);
            else push(KIND_ERROR, 0, 0, 0, ERR_NO_DATA, 1);
            clear_state();
        end
    endtask

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors = 0;
        clear_state();
    end

    always @(posedge clk) begin
        result_t x;
        if (rst_n) begin
            if (bytes.valid && bytes.ready) predict_byte(bytes.byte_value, bytes.end_of_file);
            if (results.valid && results.ready) begin
                if (expected_q.size() == 0) report("result with nothing expected");
                else begin
                    x = expected_q.pop_front();
                    if (results.kind !== x.kind)
                        report($sformatf("kind %0d, expected %0d", results.kind, x.kind));
                    if (results.mono_sample !== x.sample)
                        report($sformatf("sample %0d, expected %0d",
                                         results.mono_sample, x.sample));
                    if (results.rate_hz !== x.rate)
                        report($sformatf("rate %0d, expected %0d", results.rate_hz, x.rate));
                    if (results.channel_count !== x.chans)
                        report($sformatf("channels %0d, expected %0d",
                                         results.channel_count, x.chans));
                    if (results.error_code !== x.err)
                        report($sformatf("error %0d, expected %0d",
                                         results.error_code, x.err));
                    if (results.last !== x.last)
                        report($sformatf("last %0b, expected %0b", results.last, x.last));
                end
            end
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the WAV PCM stream decoder testbench: clock, reset, WAV file stimulus, verdict.
// Depends on wpsd_pkg, wpsd_in_if, wpsd_out_if, wpsd_checker and the decoder top.
module testbench;
    import wpsd_pkg::*;

    // Longest stretch of cycles in which neither channel completes a transaction.
    localparam int STALL_LIMIT = 4000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    bit   idling;     // random gaps on both sides when set
    bit   stim_done;

    wpsd_in_if  bytes();
    wpsd_out_if results();

    wav_pcm_stream_decoder_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes.sink),
        .results (results.source)
    );

    wpsd_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .results (results),
        .errors  (errors),
        .pending (pending)
    );

    // The file under construction; its last byte is sent with end_of_file.
    logic [7:0] file_q[$];
    int         sent;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // The result side drops ready with a chance of 29 in a hundred while idling is on.
    always @(posedge clk)
    begin
        results.ready <= idling ? ($urandom_range(99) >= 29) : 1'b1;
    end

    // The watchdog counts cycles in which no transaction completes on either side.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((bytes.valid && bytes.ready) || (results.valid && results.ready) ||
                (stim_done && pending == 0))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic put_u16(int v);
        file_q.push_back(v[7:0]);
        file_q.push_back(v[15:8]);
    endtask

    task automatic put_u32(logic [31:0] v);
        for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
    endtask

    task automatic put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
    endtask

    // One sample of data content. Floats mix random magnitudes with the special
    // encodings; PCM mixes random words with the two extremes.
    task automatic put_sample(int fmt, int bits);
        logic [31:0] f;
        int          pick;
        pick = $urandom_range(9);
        if (fmt == 3 && bits == 32)
        begin
            f = $urandom;
            case (pick)
                0: f = {f[31], 8'hFF, 23'd0};                       // infinity
                1: f = {f[31], 8'hFF, f[22:1], 1'b1};               // NaN
                2: f = {f[31], 8'h00, f[22:0]};                     // denormal
                3: f = {f[31], 8'h7F, 23'd0};                       // exactly one
                4: f = {f[31], 8'(134 + $urandom_range(3)), f[22:0]}; // beyond full scale
                default: f[30:23] = 8'(100 + $urandom_range(34));
            endcase
            put_u32(f);
        end
        else if (pick == 0) put_u16(16'h8000);
        else if (pick == 1) put_u16(16'h7FFF);
        else put_u16($urandom_range(65535));
    endtask

    // Builds a whole file. data_ok selects the data tag or a foreign tag;
    // declared data size is dlen plus over_decl; junk adds an odd chunk ahead
    // of fmt, and trailer adds bytes after the data chunk.
    task automatic build_wav(int fmt, int ch, int bits, logic [31:0] rate, int fmt_size,
                             bit data_ok, int dlen, int over_decl, bit junk, bit trailer);
        int start;
        file_q.delete();
        put_tag("RIFF");
        put_u32($urandom);
        put_tag("WAVE");
        if (junk)
        begin
            put_tag("JUNK");
            put_u32(3);
            repeat (4) file_q.push_back($urandom_range(255));
        end
        put_tag("fmt ");
        put_u32(fmt_size);
        start = file_q.size();
        put_u16(fmt);
        put_u16(ch);
        put_u32(rate);
        put_u32($urandom);
        put_u16($urandom_range(65535));
        put_u16(bits);
        while (file_q.size() - start > fmt_size) void'(file_q.pop_back());
        while (file_q.size() - start < fmt_size) file_q.push_back($urandom_range(255));
        if (fmt_size % 2 == 1) file_q.push_back(8'h00);
        put_tag(data_ok ? "data" : "LIST");
        put_u32(dlen + over_decl);
        start = file_q.size();
        while (file_q.size() - start < dlen) put_sample(fmt, bits);
        while (file_q.size() - start > dlen) void'(file_q.pop_back());
        if (trailer) repeat ($urandom_range(1, 6)) file_q.push_back($urandom_range(255));
    endtask

    // Sends the file, one transaction per byte, with random gaps while idling.
    // Valid stays high between files unless a gap is drawn.
    task automatic send_file();
        foreach (file_q[i])
        begin
            while (idling && $urandom_range(99) < 29)
            begin
                bytes.valid <= 1'b0;
                @(posedge clk);
            end
            bytes.valid       <= 1'b1;
            bytes.byte_value  <= file_q[i];
            bytes.end_of_file <= (i == file_q.size() - 1);
            do @(posedge clk); while (!bytes.ready);
            sent++;
        end
    endtask

    initial
    begin
        int fmt, ch, bits, pick, limit;
        bytes.valid       = 1'b0;
        bytes.byte_value  = 8'h00;
        bytes.end_of_file = 1'b0;
        results.ready     = 1'b0;
        idling            = 1'b1;
        stim_done         = 1'b0;
        sent              = 0;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files: each names one behavior of the parser.
        build_wav(1, 2, 16, 44100, 16, 1, 16, 0, 1, 0);      // PCM stereo, odd junk chunk
        send_file();
        build_wav(3, 1, 32, 48000, 16, 1, 40, 0, 0, 1);      // float specials, trailing bytes
        send_file();
        build_wav(1, 1, 16, 8000, 16, 1, 0, 0, 0, 0);        // empty data chunk
        send_file();
        build_wav(1, 1, 16, 8000, 16, 1, 6, 0, 0, 0);        // shorter than 44 bytes
        file_q = file_q[0:19];
        send_file();
        build_wav(1, 1, 16, 8000, 16, 1, 6, 0, 0, 0);        // bad magic
        file_q[9] = 8'h00;
        send_file();
        build_wav(1, 1, 16, 8000, 16, 0, 8, 0, 0, 0);        // no data chunk
        send_file();
        build_wav(1, 0, 16, 8000, 16, 1, 8, 0, 0, 0);        // zero channels
        send_file();
        build_wav(2, 1, 16, 8000, 16, 1, 8, 0, 0, 0);        // unsupported format code
        send_file();
        build_wav(1, 9, 16, 8000, 16, 1, 36, 0, 0, 0);       // too many channels
        send_file();
        build_wav(1, 1, 16, 8000, 14, 1, 8, 0, 0, 0);        // short fmt chunk
        send_file();
        build_wav(1, 8, 16, 32'hFFFF_FFFF, 18, 1, 37, 0, 0, 0); // 8 ch, partial frame
        send_file();
        build_wav(3, 3, 32, 0, 16, 1, 26, 20, 0, 0);         // data size beyond the file
        send_file();

        // Random files: mostly well-formed with random content, some broken, some noise.
        // The middle stretch runs with no idling at all.
        while (sent < 1750)
        begin
            idling = !(sent > 900 && sent < 1250);
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                file_q.delete();
                repeat ($urandom_range(1, 60)) file_q.push_back($urandom_range(255));
                send_file();
            end
            else
            begin
                fmt  = ($urandom_range(1)) ? 3 : 1;
                bits = (fmt == 3) ? 32 : 16;
                ch   = $urandom_range(1, 4);
                if (pick < 14) ch = $urandom_range(5, 8);
                if (pick >= 90)
                begin
                    case ($urandom_range(3))
                        0: ch = $urandom_range(9, 65535);
                        1: ch = 0;
                        2: fmt = $urandom_range(65535);
                        default: bits = $urandom_range(65535);
                    endcase
                end
                build_wav(fmt, ch, bits, $urandom, ($urandom_range(9) == 0) ? 14 +
                          $urandom_range(5) : 16, $urandom_range(19) != 0,
                          $urandom_range(0, 40), ($urandom_range(7) == 0) ? 9 : 0,
                          $urandom_range(3) == 0, $urandom_range(3) == 0);
                if ($urandom_range(15) == 0)
                    file_q = file_q[0:$urandom_range(file_q.size() - 1)];
                send_file();
            end
        end
        bytes.valid <= 1'b0;
        idling    = 1'b0;
        stim_done = 1'b1;

        limit = 0;
        while (pending != 0 && limit < 20000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
